FILE: rtl/ffa_pkg.sv
// package for the first-fit free-list allocator: status codes and sequencer states
`default_nettype none
package ffa_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_NULL    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FSCAN,
    S_FCHK,
    S_LSCAN,
    S_LCHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_ALLOC_WR,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  localparam int SIZE_BITS = 17;
  localparam logic [16:0] USED_MAX = 17'h1FFFF;
  localparam int CFG_POOL = 0;

endpackage
`default_nettype wire

FILE: rtl/first_fit_free_list_allocator_top.sv
// top level: first-fit free-list allocator with sequencer, free list and live table
// allocate scans the free list, then the live table, plus a shift of the tail on
// removal; free scans the live table
// throughput: one transfer at a time; in_stall high while busy, a waiting result holds the last state
// reset: free list holds one block of pool_bytes minus a header, live table empty
`default_nettype none
module first_fit_free_list_allocator_top
  import ffa_pkg::*;
#(
  parameter int FREE_SLOTS   = 32,
  parameter int LIVE_SLOTS   = 32,
  parameter int HEADER_BYTES = 8,
  parameter int NODE_BYTES   = 16,
  parameter int ADDR_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [15:0] request_size,
  input  wire logic [15:0] address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      address_out,
  output logic [16:0]      used_bytes
);
  localparam int FW = $clog2(FREE_SLOTS);
  localparam int LW = $clog2(LIVE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int EW = ADDR_BITS + SIZE_BITS;
  localparam logic [SIZE_BITS-1:0] HDR = SIZE_BITS'(HEADER_BYTES);
  localparam logic [SIZE_BITS-1:0] NODE = SIZE_BITS'(NODE_BYTES);

  state_t state, state_next;
  logic [16:0] pool_bytes;
  logic [CW-1:0] free_count;
  logic [16:0] used_count;
  logic [LIVE_SLOTS-1:0] live_valid;
  logic [ADDR_BITS-1:0] live_offset [LIVE_SLOTS];
  logic [15:0] live_size [LIVE_SLOTS];
  logic req_action;
  logic [15:0] req_size, req_addr;
  logic [CW-1:0] idx;
  logic [FW-1:0] hit;
  logic [LW-1:0] lidx, slot;
  logic [EW-1:0] hold;
  logic [2:0] res_status;
  logic [15:0] res_addr;
  logic [ADDR_BITS-1:0] off_hold;
  logic cfg_wr, acc, load_out;
  logic init_pend;
  logic [EW-1:0] init_word;

  logic ram_we;
  logic [FW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] rd_off;
  logic [SIZE_BITS-1:0] rd_size, leftover;

  ffa_ram #(.DEPTH(FREE_SLOTS), .WIDTH(EW)) u_free (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = 32'(pool_bytes);
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'(CFG_POOL));
  assign in_stall = rst || (state != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);
  assign rd_off = ram_rdata[EW-1:SIZE_BITS];
  assign rd_size = ram_rdata[SIZE_BITS-1:0];
  assign leftover = rd_size - SIZE_BITS'(req_size);
  // entry 0 of the free list is written through the init_pend register after reset or a pool write
  assign init_word = {ADDR_BITS'(0), (pool_bytes >= HDR) ? pool_bytes - HDR : SIZE_BITS'(0)};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (!action) state_next = (free_count == '0) ? S_DONE : S_FSCAN;
          else if (address == 16'd0 || address < 16'(HEADER_BYTES)) state_next = S_DONE;
          else state_next = S_LSCAN;
        end
      end
      S_FSCAN: state_next = S_FCHK;
      S_FCHK: begin
        if (rd_size >= SIZE_BITS'(req_size)) state_next = S_LSCAN;
        else if (idx + 1'b1 >= free_count) state_next = S_DONE;
        else state_next = S_FSCAN;
      end
      S_LSCAN: state_next = S_LCHK;
      S_LCHK: begin
        if (!req_action) begin
          if (!live_valid[lidx]) state_next = S_ALLOC_WR;
          else if (32'(lidx) == LIVE_SLOTS - 1) state_next = S_DONE;
          else state_next = S_LSCAN;
        end else begin
          if (live_valid[lidx] && live_offset[lidx] == ADDR_BITS'(req_addr - 16'(HEADER_BYTES)))
            state_next = (32'(free_count) >= FREE_SLOTS) ? S_DONE : S_FREE_WR;
          else if (32'(lidx) == LIVE_SLOTS - 1) state_next = S_DONE;
          else state_next = S_LSCAN;
        end
      end
      S_ALLOC_WR: begin
        if (hold[SIZE_BITS-1:0] >= NODE && hold[SIZE_BITS-1:0] >= HDR) state_next = S_DONE;
        else if (CW'(hit) + 1'b1 >= free_count) state_next = S_DONE;
        else state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (idx + 1'b1 >= free_count) ? S_DONE : S_SHIFT_RD;
      S_FREE_RD: state_next = S_FREE_WR;
      S_FREE_WR: state_next = S_DONE;
      S_DONE: state_next = load_out ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = hit;
    ram_wdata = hold;
    ram_raddr = FW'(idx);
    unique case (state)
      S_SHIFT_RD: ram_raddr = FW'(idx + 1'b1);
      S_SHIFT_WR: begin
        ram_we = 1'b1;
        ram_waddr = FW'(idx);
        ram_wdata = ram_rdata;
      end
      S_ALLOC_WR: begin
        if (hold[SIZE_BITS-1:0] >= NODE && hold[SIZE_BITS-1:0] >= HDR) begin
          ram_we = 1'b1;
          ram_wdata = {ADDR_BITS'(off_hold + ADDR_BITS'(req_size) + ADDR_BITS'(HEADER_BYTES)),
                       hold[SIZE_BITS-1:0] - HDR};
        end
      end
      S_FREE_WR: begin
        ram_we = 1'b1;
        ram_waddr = FW'(free_count);
        ram_wdata = {live_offset[lidx], SIZE_BITS'(live_size[lidx])};
      end
      default: ;
    endcase
    if (init_pend) begin
      ram_we = 1'b1;
      ram_waddr = '0;
      ram_wdata = init_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      free_count <= CW'(1);
      used_count <= '0;
      live_valid <= '0;
      init_pend <= 1'b1;
      if (rst) pool_bytes <= 17'd65536;
      else pool_bytes <= pwdata[16:0];
    end else begin
      state <= state_next;
      init_pend <= 1'b0;
      if (load_out) begin
        out_valid <= 1'b1;
        status <= res_status;
        address_out <= res_addr;
        used_bytes <= used_count;
      end else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            req_action <= action;
            req_size <= request_size;
            req_addr <= address;
            idx <= '0;
            lidx <= '0;
            res_addr <= '0;
            if (!action) res_status <= (free_count == '0) ? ST_EMPTY : ST_NO_FIT;
            else res_status <= (address == 16'd0) ? ST_NULL : ST_UNKNOWN;
          end
        end
        S_FCHK: begin
          if (rd_size >= SIZE_BITS'(req_size)) begin
            hit <= FW'(idx);
            off_hold <= rd_off;
            hold <= {rd_off, leftover};
            res_status <= ST_FULL;
          end else idx <= idx + 1'b1;
        end
        S_LCHK: begin
          if (!req_action) begin
            if (!live_valid[lidx]) slot <= lidx;
            else lidx <= lidx + 1'b1;
          end else if (!(live_valid[lidx] &&
                         live_offset[lidx] == ADDR_BITS'(req_addr - 16'(HEADER_BYTES)))) begin
            lidx <= lidx + 1'b1;
          end else if (32'(free_count) >= FREE_SLOTS) res_status <= ST_FULL;
        end
        S_ALLOC_WR: begin
          live_offset[slot] <= off_hold;
          live_size[slot] <= req_size;
          live_valid[slot] <= 1'b1;
          used_count <= ({1'b0, used_count} + 18'(req_size) + 18'(HEADER_BYTES) > 18'(USED_MAX))
                        ? USED_MAX : 17'(used_count + 17'(req_size) + HDR);
          res_status <= ST_OK;
          res_addr <= 16'(off_hold + ADDR_BITS'(HEADER_BYTES));
          idx <= CW'(hit);
          if (!(hold[SIZE_BITS-1:0] >= NODE && hold[SIZE_BITS-1:0] >= HDR))
            free_count <= free_count - 1'b1;
        end
        S_SHIFT_WR: idx <= idx + 1'b1;
        S_FREE_WR: begin
          free_count <= free_count + 1'b1;
          live_valid[lidx] <= 1'b0;
          used_count <= (used_count > 17'(live_size[lidx]) + HDR)
                        ? used_count - 17'(live_size[lidx]) - HDR : '0;
          res_status <= ST_OK;
        end
        default: ;
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !cfg_wr) |=> (out_valid && $stable(status) &&
      $stable(address_out) && $stable(used_bytes)));
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(free_count) <= FREE_SLOTS);
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_NULL));
endmodule
`default_nettype wire

FILE: rtl/ffa_ram.sv
// simple dual-port table memory (one write port, one read port) with registered read for the free list
`default_nettype none
module ffa_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/first_fit_free_list_allocator_top_test.sv
// testbench for the first-fit free-list allocator: directed table, random traffic, predictor
`default_nettype none
module first_fit_free_list_allocator_top_test;
  import ffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FREE_N = 32;
  localparam int LIVE_N = 32;
  localparam int HDR = 8;
  localparam int NODE = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    int status;
    int addr;
    int used;
  } alloc_result_t;

  typedef struct {
    bit act;
    int req;
    int adr;
    bit typed;
    int status;
    int addr;
    int used;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic [15:0] request_size = '0;
  logic [15:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] address_out;
  logic [16:0] used_bytes;

  first_fit_free_list_allocator_top i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .request_size(request_size), .address(address),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .address_out(address_out), .used_bytes(used_bytes)
  );

  always #5 clk = ~clk;

  // predictor state
  int fl_off [FREE_N];
  int fl_size [FREE_N];
  int fl_count;
  int lt_off [LIVE_N];
  int lt_size [LIVE_N];
  bit lt_vld [LIVE_N];
  int used_total;
  int pool_cfg;

  alloc_result_t pending_results[$];
  logic [15:0] live_addrs[$];
  int fails = 0;
  int transfers_in = 0;
  int transfers_out = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int ok_count = 0;

  task automatic reset_pool(input int pool);
    pool_cfg = pool;
    for (int i = 0; i < FREE_N; i++) begin
      fl_off[i] = 0;
      fl_size[i] = 0;
    end
    for (int i = 0; i < LIVE_N; i++) begin
      lt_off[i] = 0;
      lt_size[i] = 0;
      lt_vld[i] = 1'b0;
    end
    fl_size[0] = (pool >= HDR) ? pool - HDR : 0;
    fl_count = 1;
    used_total = 0;
  endtask

  task automatic predict_allocator(input bit act, input int req, input int adr,
                                   output alloc_result_t r);
    int hit;
    int slot;
    int off;
    int left;
    int charge;
    r.status = ST_OK;
    r.addr = 0;
    if (!act) begin
      hit = -1;
      slot = -1;
      for (int i = 0; i < fl_count; i++)
        if (hit < 0 && fl_size[i] >= req) hit = i;
      for (int i = 0; i < LIVE_N; i++)
        if (slot < 0 && !lt_vld[i]) slot = i;
      if (fl_count == 0) r.status = ST_EMPTY;
      else if (hit < 0) r.status = ST_NO_FIT;
      else if (slot < 0) r.status = ST_FULL;
      else begin
        off = fl_off[hit];
        left = fl_size[hit] - req;
        if (left >= NODE && left >= HDR) begin
          fl_off[hit] = (off + req + HDR) & 16'hFFFF;
          fl_size[hit] = (left - HDR) & 17'h1FFFF;
        end else begin
          for (int i = hit; i + 1 < fl_count; i++) begin
            fl_off[i] = fl_off[i + 1];
            fl_size[i] = fl_size[i + 1];
          end
          fl_count--;
        end
        lt_off[slot] = off;
        lt_size[slot] = req;
        lt_vld[slot] = 1'b1;
        used_total = (used_total + req + HDR > USED_MAX) ? USED_MAX : used_total + req + HDR;
        r.addr = (off + HDR) & 16'hFFFF;
      end
    end else if (adr == 0) begin
      r.status = ST_NULL;
    end else begin
      slot = -1;
      if (adr >= HDR)
        for (int i = 0; i < LIVE_N; i++)
          if (slot < 0 && lt_vld[i] && lt_off[i] == adr - HDR) slot = i;
      if (slot < 0) r.status = ST_UNKNOWN;
      else if (fl_count >= FREE_N) r.status = ST_FULL;
      else begin
        fl_off[fl_count] = lt_off[slot];
        fl_size[fl_count] = lt_size[slot];
        fl_count++;
        lt_vld[slot] = 1'b0;
        charge = lt_size[slot] + HDR;
        used_total = (used_total > charge) ? used_total - charge : 0;
      end
    end
    r.used = used_total;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // one transfer on the request channel, predicted at the edge that takes it
  task automatic send_request(input bit act, input int req, input int adr,
                              input bit typed, input alloc_result_t typed_r);
    alloc_result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    request_size <= req[15:0];
    address <= adr[15:0];
    do @(posedge clk); while (in_stall);
    transfers_in++;
    predict_allocator(act, req, adr, r);
    if (typed) r = typed_r;
    pending_results.push_back(r);
    if (r.status == ST_OK) begin
      ok_count++;
      if (!act) live_addrs.push_back(r.addr[15:0]);
      else
        for (int i = 0; i < live_addrs.size(); i++)
          if (live_addrs[i] == adr[15:0]) begin
            live_addrs.delete(i);
            break;
          end
    end
  endtask

  task automatic write_pool(input int pool);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(CFG_POOL * 4);
    pwdata <= pool;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reset_pool(pool);
    live_addrs.delete();
    @(posedge clk);
  endtask

  task automatic random_phase(input int pool, input int count);
    int req;
    int adr;
    bit act;
    alloc_result_t none;
    none = '{0, 0, 0};
    for (int k = 0; k < count; k++) begin
      act = ($urandom_range(99) >= (((k / 35) % 2) ? 25 : 85));
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: req = $urandom_range(64);
        6, 7, 8: req = $urandom_range(4096);
        default: req = $urandom & 16'hFFFF;
      endcase
      if (pool < 1024 && $urandom_range(3) != 0) req = $urandom_range(pool);
      adr = $urandom & 16'hFFFF;
      if (act && live_addrs.size() != 0 && $urandom_range(9) < 8)
        adr = live_addrs[$urandom_range(live_addrs.size() - 1)];
      else if (act && $urandom_range(2) == 0)
        adr = $urandom_range(HDR - 1);
      send_request(act, req, adr, 1'b0, none);
    end
  endtask

  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      transfers_out++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transfer", transfers_out, transfers_in);
      end else begin
        want = pending_results.pop_front();
        if (status != want.status) report_mismatch("status", status, want.status);
        if (address_out != want.addr) report_mismatch("address_out", address_out, want.addr);
        if (used_bytes != want.used) report_mismatch("used_bytes", used_bytes, want.used);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("FAIL first_fit_free_list_allocator_top");
      $finish;
    end
  end

  dir_row_t directed [13] = '{
    '{1'b1, 0, 0, 1'b1, ST_NULL, 0, 0},
    '{1'b1, 0, 4, 1'b1, ST_UNKNOWN, 0, 0},
    '{1'b0, 65535, 65535, 1'b1, ST_NO_FIT, 0, 0},
    '{1'b0, 0, 0, 1'b1, ST_OK, 8, 8},
    '{1'b0, 65520, 0, 1'b1, ST_OK, 16, 65536},
    '{1'b0, 1, 0, 1'b1, ST_EMPTY, 0, 65536},
    '{1'b1, 0, 16, 1'b1, ST_OK, 0, 8},
    '{1'b1, 0, 65535, 1'b1, ST_UNKNOWN, 0, 8},
    '{1'b1, 65535, 8, 1'b1, ST_OK, 0, 0},
    '{1'b0, 100, 0, 1'b0, 0, 0, 0},
    '{1'b0, 5000, 65535, 1'b0, 0, 0, 0},
    '{1'b0, 0, 0, 1'b0, 0, 0, 0},
    '{1'b1, 0, 16, 1'b0, 0, 0, 0}
  };

  int pools [7] = '{65536, 64, 1000, 65536, 200, 65536, 64};

  initial begin
    alloc_result_t typed_r;
    reset_pool(65536);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_pool(65536);
    foreach (directed[i]) begin
      typed_r = '{directed[i].status, directed[i].addr, directed[i].used};
      send_request(directed[i].act, directed[i].req, directed[i].adr,
                   directed[i].typed, typed_r);
    end
    foreach (pools[p]) begin
      write_pool(pools[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 49; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 49; end
        default: begin sender_idle_pct = 32; stall_pct = 32; end
      endcase
      if (p == 3) hold_requests++;
      random_phase(pools[p], 120);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d requests and %0d results over %0d pool sizes, %0d succeeded",
             transfers_in, transfers_out, $size(pools), ok_count);
    if (fails == 0) begin
      $display("PASS first_fit_free_list_allocator_top");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAIL first_fit_free_list_allocator_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
